// File: sv/sfc_pkg.sv
// shared types and constants for the stereo fir convolver
package sfc_pkg;

    // request kinds carried in tuser
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_COEF   = 2'd1,
        CMD_COMMIT = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd1;
    localparam int CFG_DATA_W = 9;

    localparam int TAP_INDEX_W = 8;
    localparam int COEF_FRAC   = 16;

    // accepted request, decoded for the sequencer
    typedef struct packed {
        logic sample;
        logic filt;
        logic commit;
    } t_req;

    // sequencer status towards the top level
    typedef struct packed {
        logic ready;
        logic done;
        logic clearing;
    } t_seq_stat;

    // control of the shared multiply-accumulate pair
    typedef struct packed {
        logic clr;
        logic en;
        logic zero;
    } t_mac_ctl;

endpackage

// File: sv/sfc_ram.sv
// generic single write port ram with registered read
module sfc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/sfc_mac.sv
// one multiply-accumulate lane with floor shift and saturation
module sfc_mac
    import sfc_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 18,
    parameter int ACC_W       = 51
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mac_ctl                      i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_smp,
    input  logic signed [COEF_BITS-1:0]   i_coef,
    output logic signed [SAMPLE_BITS-1:0] o_result
);
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int SH_W   = ACC_W - COEF_FRAC;
    localparam logic signed [SH_W-1:0] SAT_HI = SH_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic                     r_pvld;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SH_W-1:0]   w_sh;

    always_comb begin
        n_prod = i_smp * i_coef;
        if (i_ctl.zero) begin
            n_prod = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_ctl.en;
        end
    end

    // product stage, then accumulate stage
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_pvld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // arithmetic shift rounds toward minus infinity
    assign w_sh = SH_W'(r_acc >>> COEF_FRAC);

    always_comb begin
        if (w_sh > SAT_HI) begin
            o_result = SAT_HI[SAMPLE_BITS-1:0];
        end else if (w_sh < SAT_LO) begin
            o_result = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            o_result = w_sh[SAMPLE_BITS-1:0];
        end
    end
endmodule

// File: sv/sfc_seq.sv
// sequencer: coefficient clear and commit sweeps, tap walk, delay line position
module sfc_seq
    import sfc_pkg::*;
#(
    parameter int MAX_TAPS = 256
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  t_req                                              i_req,
    input  logic                                              i_clr_line,
    input  logic [$clog2(MAX_TAPS+1)-1:0]                     i_tap_count,
    input  logic                                              i_out_free,
    output t_seq_stat                                         o_stat,
    output t_mac_ctl                                          o_mac,
    output logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0]  o_pos,
    output logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0]  o_line_raddr,
    output logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0]  o_sweep,
    output logic                                              o_cur_we,
    output logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0]  o_cur_waddr
);
    localparam int AW    = MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1;
    localparam int TAP_W = $clog2(MAX_TAPS+1);
    localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_TAPS - 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_COPY   = 7'b0000100,
        S_RUN    = 7'b0001000,
        S_DRAIN1 = 7'b0010000,
        S_DRAIN2 = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_k, n_k;
    logic [AW-1:0]     r_rd, n_rd;
    logic [AW-1:0]     r_pos, n_pos;
    logic [TAP_W-1:0]  r_fill, n_fill;
    logic              r_rd_vld;
    logic              r_rd_zero;
    logic              r_cp_vld;
    logic [AW-1:0]     r_cp_addr;
    logic [TAP_W-1:0]  w_last_tap;
    logic              w_start;

    assign w_last_tap = i_tap_count - TAP_W'(1);
    assign w_start    = (r_state == S_IDLE) && i_req.sample && i_req.filt;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_rd    = r_rd;
        n_pos   = r_pos;
        n_fill  = r_fill;
        case (r_state)
            S_CLEAR: begin
                n_k = r_k + AW'(1);
                if (r_k == LAST_ENTRY) begin
                    n_k     = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.commit) begin
                    n_k     = '0;
                    n_state = S_COPY;
                end else if (i_req.sample) begin
                    if (i_req.filt) begin
                        n_k     = '0;
                        n_rd    = r_pos;
                        n_pos   = (TAP_W'(r_pos) == w_last_tap) ? '0 : r_pos + AW'(1);
                        if (TAP_W'(r_pos) >= r_fill) begin
                            n_fill = TAP_W'(r_pos) + TAP_W'(1);
                        end
                        n_state = S_RUN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_COPY: begin
                n_k = r_k + AW'(1);
                if (r_k == LAST_ENTRY) begin
                    n_k     = '0;
                    n_state = S_IDLE;
                end
            end
            S_RUN: begin
                n_k  = r_k + AW'(1);
                // walk back through the circular line
                n_rd = (r_rd == '0) ? AW'(w_last_tap) : r_rd - AW'(1);
                if (TAP_W'(r_k) == w_last_tap) begin
                    n_state = S_DRAIN1;
                end
            end
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_DONE;
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // a tap count write restarts the line
        if (i_clr_line) begin
            n_pos  = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_k      <= '0;
            r_pos    <= '0;
            r_fill   <= '0;
            r_rd_vld <= 1'b0;
            r_cp_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_pos    <= n_pos;
            r_fill   <= n_fill;
            r_rd_vld <= (r_state == S_RUN);
            r_cp_vld <= (r_state == S_COPY);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd      <= n_rd;
        r_rd_zero <= !(TAP_W'(r_rd) < r_fill);
        r_cp_addr <= r_k;
    end

    assign o_stat.ready    = (r_state == S_IDLE);
    assign o_stat.done     = (r_state == S_DONE);
    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_mac.clr       = w_start;
    assign o_mac.en        = r_rd_vld;
    assign o_mac.zero      = r_rd_zero;
    assign o_pos           = r_pos;
    assign o_line_raddr    = r_rd;
    assign o_sweep         = r_k;
    assign o_cur_we        = (r_state == S_CLEAR) || r_cp_vld;
    assign o_cur_waddr     = (r_state == S_CLEAR) ? r_k : r_cp_addr;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        TAP_W'(r_pos) < i_tap_count)
        else $error("write position beyond tap count");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= i_tap_count)
        else $error("delay line fill beyond tap count");

    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr_line |=> (r_pos == '0) && (r_fill == '0))
        else $error("tap count write did not restart the line");

    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !r_rd_vld && !o_mac.en)
        else $error("result offered before the tap walk drained");
endmodule

// File: sv/stereo_fir_convolver_top.sv
// top level of the stereo fir convolver: stream ports, configuration, banks and line
// One mono sample in, one left/right pair out. Each ear sums coefficient times delayed
// sample over tap_count taps of a shared circular delay line, shifts down by 16 with
// floor rounding and saturates to SAMPLE_BITS. For a filtered sample the line is
// written at the accepting edge, then the taps are read in turn through the single
// read port of the delay line and coefficient ram, feeding the shared left/right
// multiply-accumulate pair, followed by pipeline drain and the result hand-off, which
// waits while the output register holds an untaken pair; tready rises again at the
// edge that loads the result register. A sample with the filter disabled goes straight
// to the result hand-off; a coefficient write and an unused command keep tready high.
// A commit copies the target bank into the current bank, one entry per cycle. After
// reset the block clears every entry of both coefficient banks before tready rises;
// configuration writes are taken throughout. The delay line needs no clearing pass:
// a fill count marks which entries have been written since reset or the last tap
// count write, and unwritten entries read as zero. Only one request is in progress
// at a time; a finished pair waits in the output register without blocking acceptance
// of the next request, whose own result waits until that pair is taken.
module stereo_fir_convolver_top
    import sfc_pkg::*;
#(
    parameter int MAX_TAPS    = 256,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 18
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // request stream
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // tdata: sample, tap_index, coef_left, coef_right, zero padding
    input  logic [((SAMPLE_BITS+TAP_INDEX_W+2*COEF_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: command
    input  logic [1:0]               i_s_axis_tuser,
    // result stream
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // tdata: out_left, out_right, zero padding
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] o_m_axis_tdata
);
    localparam int AW      = MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1;
    localparam int TAP_W   = $clog2(MAX_TAPS+1);
    localparam int OUT_W   = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int IDX_LO  = SAMPLE_BITS;
    localparam int CL_LO   = SAMPLE_BITS + TAP_INDEX_W;
    localparam int CR_LO   = CL_LO + COEF_BITS;
    localparam int ACC_RAW = SAMPLE_BITS + COEF_BITS + TAP_W;
    // keep at least one bit above the sample range after the shift
    localparam int ACC_W   = ACC_RAW > SAMPLE_BITS + COEF_FRAC + 1 ?
                             ACC_RAW : SAMPLE_BITS + COEF_FRAC + 1;
    localparam int BANK_W  = 2 * COEF_BITS;

    // request fields
    t_cmd                          w_cmd;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic [TAP_INDEX_W-1:0]        w_tap_index;
    logic [COEF_BITS-1:0]          w_coef_left;
    logic [COEF_BITS-1:0]          w_coef_right;
    logic                          w_in_acc;
    logic                          w_cfg_acc;

    // configuration
    logic                          r_filt_en;
    logic [TAP_W-1:0]              r_taps, n_taps;
    logic                          w_clr_line;

    // sequencer
    t_req                          w_req;
    t_seq_stat                     w_stat;
    t_mac_ctl                      w_mac;
    logic [AW-1:0]                 w_pos;
    logic [AW-1:0]                 w_line_raddr;
    logic [AW-1:0]                 w_sweep;
    logic                          w_cur_we;
    logic [AW-1:0]                 w_cur_waddr;

    // memories
    logic                          w_line_we;
    logic signed [SAMPLE_BITS-1:0] w_line_rdata;
    logic                          w_tgt_we;
    logic [AW-1:0]                 w_tgt_waddr;
    logic [BANK_W-1:0]             w_tgt_wdata;
    logic [BANK_W-1:0]             w_tgt_rdata;
    logic [BANK_W-1:0]             w_cur_wdata;
    logic [BANK_W-1:0]             w_cur_rdata;

    // results
    logic signed [SAMPLE_BITS-1:0] w_mac_left;
    logic signed [SAMPLE_BITS-1:0] w_mac_right;
    logic                          r_byp;
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic                          r_m_valid;
    logic [SAMPLE_BITS-1:0]        r_left;
    logic [SAMPLE_BITS-1:0]        r_right;
    logic                          w_out_free;

    assign w_cmd        = t_cmd'(i_s_axis_tuser);
    assign w_sample     = i_s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_tap_index  = i_s_axis_tdata[IDX_LO +: TAP_INDEX_W];
    assign w_coef_left  = i_s_axis_tdata[CL_LO +: COEF_BITS];
    assign w_coef_right = i_s_axis_tdata[CR_LO +: COEF_BITS];

    assign o_s_axis_tready = w_stat.ready;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_clr_line  = w_cfg_acc && (i_cfg_index == CFG_TAP_COUNT);

    // tap count clamps to the range one to MAX_TAPS
    always_comb begin
        if (i_cfg_data == '0) begin
            n_taps = TAP_W'(1);
        end else if (32'(i_cfg_data) > MAX_TAPS) begin
            n_taps = TAP_W'(MAX_TAPS);
        end else begin
            n_taps = TAP_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_en <= 1'b0;
            r_taps    <= TAP_W'(MAX_TAPS);
        end else if (w_cfg_acc) begin
            case (i_cfg_index)
                CFG_FILTER_EN: r_filt_en <= i_cfg_data[0];
                CFG_TAP_COUNT: r_taps    <= n_taps;
                default:       ;
            endcase
        end
    end

    // decoded request for the sequencer
    assign w_req.sample = w_in_acc && (w_cmd == CMD_SAMPLE);
    assign w_req.filt   = r_filt_en;
    assign w_req.commit = w_in_acc && (w_cmd == CMD_COMMIT);

    sfc_seq #(
        .MAX_TAPS (MAX_TAPS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_req),
        .i_clr_line   (w_clr_line),
        .i_tap_count  (r_taps),
        .i_out_free   (w_out_free),
        .o_stat       (w_stat),
        .o_mac        (w_mac),
        .o_pos        (w_pos),
        .o_line_raddr (w_line_raddr),
        .o_sweep      (w_sweep),
        .o_cur_we     (w_cur_we),
        .o_cur_waddr  (w_cur_waddr)
    );

    // delay line: an accepted sample goes in at the write position when the filter is enabled
    assign w_line_we = w_req.sample && r_filt_en;

    sfc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_waddr (w_pos),
        .i_wdata (w_sample),
        .i_raddr (w_line_raddr),
        .o_rdata (w_line_rdata)
    );

    // target bank: zeroed by the clearing pass, then written by coefficient requests
    always_comb begin
        if (w_stat.clearing) begin
            w_tgt_we    = 1'b1;
            w_tgt_waddr = w_sweep;
            w_tgt_wdata = '0;
        end else begin
            w_tgt_we    = w_in_acc && (w_cmd == CMD_COEF) &&
                          (32'(w_tap_index) < MAX_TAPS);
            w_tgt_waddr = AW'(w_tap_index);
            w_tgt_wdata = {w_coef_right, w_coef_left};
        end
    end

    sfc_ram #(
        .WIDTH (BANK_W),
        .DEPTH (MAX_TAPS)
    ) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (w_tgt_we),
        .i_waddr (w_tgt_waddr),
        .i_wdata (w_tgt_wdata),
        .i_raddr (w_sweep),
        .o_rdata (w_tgt_rdata)
    );

    // current bank: zeroed by the clearing pass, filled from the target bank on commit
    assign w_cur_wdata = w_stat.clearing ? '0 : w_tgt_rdata;

    sfc_ram #(
        .WIDTH (BANK_W),
        .DEPTH (MAX_TAPS)
    ) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (w_cur_we),
        .i_waddr (w_cur_waddr),
        .i_wdata (w_cur_wdata),
        .i_raddr (w_sweep),
        .o_rdata (w_cur_rdata)
    );

    // shared multiply-accumulate pair, one lane per ear
    sfc_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .ACC_W       (ACC_W)
    ) u_mac_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac),
        .i_smp    (w_line_rdata),
        .i_coef   (w_cur_rdata[COEF_BITS-1:0]),
        .o_result (w_mac_left)
    );

    sfc_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .ACC_W       (ACC_W)
    ) u_mac_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac),
        .i_smp    (w_line_rdata),
        .i_coef   (w_cur_rdata[BANK_W-1:COEF_BITS]),
        .o_result (w_mac_right)
    );

    // sample kept for pass-through when the filter is off
    always_ff @(posedge i_clk) begin
        if (w_req.sample) begin
            r_byp <= !r_filt_en;
            r_smp <= w_sample;
        end
    end

    // output register parts the result stream from the sequencer
    assign w_out_free = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_stat.done && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.done && w_out_free) begin
            r_left  <= r_byp ? r_smp : w_mac_left;
            r_right <= r_byp ? r_smp : w_mac_right;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = OUT_W'({r_right, r_left});
endmodule

// File: verif/stereo_fir_convolver_checker.sv
`timescale 1ns / 1ps
// scoreboard for the stereo fir convolver: tracks register writes, predicts and compares pairs
module stereo_fir_convolver_checker
    import sfc_pkg::*;
#(
    parameter int MAX_TAPS    = 256,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 18,
    parameter int IN_W        = 72,
    parameter int OUT_W       = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [IN_W-1:0]       i_req_data,
    input  logic [1:0]            i_req_kind,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [OUT_W-1:0]      i_res_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_pairs_checked
);

    localparam int MAX_REPORTS = 10;

    typedef logic signed [SAMPLE_BITS-1:0] t_smp;
    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef struct {
        t_smp left;
        t_smp right;
    } t_pair;

    t_smp        line_mem [MAX_TAPS];
    t_coef       live_l   [MAX_TAPS];
    t_coef       live_r   [MAX_TAPS];
    t_coef       staged_l [MAX_TAPS];
    t_coef       staged_r [MAX_TAPS];
    logic        filt_on;
    int unsigned taps;
    int unsigned wpos;
    t_pair       pair_q [$];

    function automatic void clear_line();
        foreach (line_mem[i]) line_mem[i] = '0;
        wpos = 0;
    endfunction

    function automatic void reset_model();
        clear_line();
        foreach (live_l[i]) begin
            live_l[i]   = '0;
            live_r[i]   = '0;
            staged_l[i] = '0;
            staged_r[i] = '0;
        end
        filt_on = 1'b0;
        taps    = MAX_TAPS;
        pair_q.delete();
        o_mismatches    = 0;
        o_pairs_checked = 0;
    endfunction

    // floor shift by the coefficient fraction, then clamp to the sample range
    function automatic t_smp scale_sat(longint acc);
        longint top, bottom, shifted;
        top     = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        bottom  = -top - 1;
        shifted = acc >>> COEF_FRAC;
        if (shifted > top)
            shifted = top;
        else if (shifted < bottom)
            shifted = bottom;
        return t_smp'(shifted);
    endfunction

    function automatic t_pair filter_sample(t_smp s);
        t_pair       pr;
        longint      acc_l, acc_r;
        int unsigned slot;
        if (!filt_on) begin
            pr.left  = s;
            pr.right = s;
            return pr;
        end
        line_mem[wpos] = s;
        acc_l = 0;
        acc_r = 0;
        for (int unsigned k = 0; k < taps; k++) begin
            slot  = (wpos + taps - k) % taps;
            acc_l += longint'(live_l[k]) * longint'(line_mem[slot]);
            acc_r += longint'(live_r[k]) * longint'(line_mem[slot]);
        end
        pr.left  = scale_sat(acc_l);
        pr.right = scale_sat(acc_r);
        wpos = (wpos + 1) % taps;
        return pr;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_FILTER_EN) begin
            filt_on = val[0];
        end else if (idx == CFG_TAP_COUNT) begin
            if (val == 0)
                taps = 1;
            else if (val > MAX_TAPS)
                taps = MAX_TAPS;
            else
                taps = 32'(val);
            clear_line();
        end
    endfunction

    function automatic void take_request(t_cmd kind, logic [IN_W-1:0] data);
        int unsigned idx;
        case (kind)
            CMD_SAMPLE: pair_q.push_back(filter_sample(data[0 +: SAMPLE_BITS]));
            CMD_COEF: begin
                idx = 32'(data[SAMPLE_BITS +: TAP_INDEX_W]);
                if (idx < MAX_TAPS) begin
                    staged_l[idx] = data[SAMPLE_BITS + TAP_INDEX_W +: COEF_BITS];
                    staged_r[idx] = data[SAMPLE_BITS + TAP_INDEX_W + COEF_BITS +: COEF_BITS];
                end
            end
            CMD_COMMIT: begin
                live_l = staged_l;
                live_r = staged_r;
            end
            default: ;
        endcase
    endfunction

    function automatic void note_mismatch(string what);
        o_mismatches++;
        if (o_mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endfunction

    // results are compared before the new request is absorbed, so a stray pair
    // can never pair up with an expectation raised on the same edge
    always @(posedge i_clk) begin
        t_pair want;
        t_smp  got_l, got_r;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got_l = i_res_data[0 +: SAMPLE_BITS];
                got_r = i_res_data[SAMPLE_BITS +: SAMPLE_BITS];
                if (pair_q.size() == 0) begin
                    note_mismatch($sformatf("pair left %0d right %0d with none pending",
                                            got_l, got_r));
                end else begin
                    want = pair_q.pop_front();
                    o_pairs_checked++;
                    if (got_l !== want.left)
                        note_mismatch($sformatf("left expected %0d got %0d", want.left, got_l));
                    if (got_r !== want.right)
                        note_mismatch($sformatf("right expected %0d got %0d",
                                                want.right, got_r));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                apply_cfg(i_cfg_index, i_cfg_data);
            if (i_req_valid && i_req_ready)
                take_request(t_cmd'(i_req_kind), i_req_data);
        end
        o_pending = pair_q.size();
    end

endmodule

// File: verif/stereo_fir_convolver_top_tb.sv
`timescale 1ns / 1ps
// testbench top for the stereo fir convolver: request traffic, register settings and verdict
module stereo_fir_convolver_top_tb;
    import sfc_pkg::*;

    localparam int MAX_TAPS     = 256;
    localparam int SAMPLE_BITS  = 24;
    localparam int COEF_BITS    = 18;
    localparam int FIELD_W      = SAMPLE_BITS + TAP_INDEX_W + 2 * COEF_BITS;
    localparam int IN_W         = ((FIELD_W + 7) / 8) * 8;
    localparam int OUT_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 600;
    localparam int N_PHASES     = 9;
    // longest requests are a commit over every bank entry and a filter pass over MAX_TAPS taps
    localparam int DRAIN_CYCLES = MAX_TAPS + 48;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [COEF_BITS-1:0]   COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic signed [COEF_BITS-1:0]   COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // tdata: sample, tap_index, coef_left, coef_right, zero padding
    logic [IN_W-1:0]       i_s_axis_tdata;
    // tuser: command
    logic [1:0]            i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // tdata: out_left, out_right, zero padding
    logic [OUT_W-1:0]      o_m_axis_tdata;

    int mismatches;
    int pending;
    int pairs_checked;
    int cycle_cnt;

    // idling switches, flipped now and then so that both gappy and back-to-back
    // stretches occur on each side
    bit req_idle_on = 1'b1;
    bit res_idle_on = 1'b1;

    int n_samples, n_coefs, n_commits, n_unused, n_cfg_writes, n_settings;

    // register settings per random phase: enable word, tap count word
    // (out-of-range tap counts and enable words with spare bits set included)
    logic [CFG_DATA_W-1:0] phase_en   [N_PHASES] = '{9'h001, 9'h1FF, 9'h001, 9'h0FE, 9'h001,
                                                     9'h001, 9'h001, 9'h000, 9'h001};
    logic [CFG_DATA_W-1:0] phase_taps [N_PHASES] = '{9'd0, 9'd1, 9'd256, 9'd37, 9'd300,
                                                     9'd3, 9'd511, 9'd16, 9'd16};

    stereo_fir_convolver_top #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    stereo_fir_convolver_checker #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .IN_W        (IN_W),
        .OUT_W       (OUT_W)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_valid     (i_s_axis_tvalid),
        .i_req_ready     (o_s_axis_tready),
        .i_req_data      (i_s_axis_tdata),
        .i_req_kind      (i_s_axis_tuser),
        .i_res_valid     (o_m_axis_tvalid),
        .i_res_ready     (i_m_axis_tready),
        .i_res_data      (o_m_axis_tdata),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_pairs_checked (pairs_checked)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // watchdog: ends a hung run
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random stall before each pair, sometimes none at all
    initial begin : result_sink
        int gap;
        i_m_axis_tready = 1'b0;
        forever begin
            if ($urandom_range(0, 29) == 0)
                res_idle_on = !res_idle_on;
            gap = res_idle_on ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                i_m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
        end
    end

    // fields from the lowest bit up: sample, tap index, left coef, right coef
    function automatic logic [IN_W-1:0] pack_req(logic [SAMPLE_BITS-1:0] smp,
                                                 logic [TAP_INDEX_W-1:0] tap,
                                                 logic [COEF_BITS-1:0]   cl,
                                                 logic [COEF_BITS-1:0]   cr);
        return {{(IN_W - FIELD_W){1'b0}}, cr, cl, tap, smp};
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        if ($urandom_range(0, 7) != 0)
            return SAMPLE_BITS'($urandom);
        case ($urandom_range(0, 4))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return '0;
            3:       return SAMPLE_BITS'(1);
            default: return '1;
        endcase
    endfunction

    // mostly modest coefficients so that long filters do not always clip
    function automatic logic signed [COEF_BITS-1:0] rand_coef();
        logic signed [COEF_BITS-1:0] mag;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return '0;
                    3:       return COEF_BITS'(1);
                    default: return '1;
                endcase
            end
            1, 2: begin
                mag = COEF_BITS'($urandom_range(0, 4095));
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default: return COEF_BITS'($urandom);
        endcase
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_cfg_writes++;
    endtask

    // one request: optional gap with tvalid low, then hold until the handshake
    task automatic send_req(t_cmd kind, logic [IN_W-1:0] data);
        int gap;
        gap = req_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        case (kind)
            CMD_SAMPLE: n_samples++;
            CMD_COEF:   n_coefs++;
            CMD_COMMIT: n_commits++;
            default:    n_unused++;
        endcase
    endtask

    // fields a request does not use carry random bits
    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s);
        send_req(CMD_SAMPLE, pack_req(s, TAP_INDEX_W'($urandom), COEF_BITS'($urandom),
                                      COEF_BITS'($urandom)));
    endtask

    task automatic send_coef(logic [TAP_INDEX_W-1:0] tap, logic signed [COEF_BITS-1:0] cl,
                             logic signed [COEF_BITS-1:0] cr);
        send_req(CMD_COEF, pack_req(SAMPLE_BITS'($urandom), tap, cl, cr));
    endtask

    task automatic send_plain(t_cmd kind);
        send_req(kind, pack_req(SAMPLE_BITS'($urandom), TAP_INDEX_W'($urandom),
                                COEF_BITS'($urandom), COEF_BITS'($urandom)));
    endtask

    // drop tvalid and hold off until every predicted pair has been taken
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // a commit may still be running with nothing pending
    task automatic settle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_request(int unsigned live_taps);
        int unsigned pick;
        if ($urandom_range(0, 29) == 0)
            req_idle_on = !req_idle_on;
        if ($urandom_range(0, 79) == 0)
            wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 60)
            send_sample(rand_sample());
        else if (pick < 85)
            send_coef(TAP_INDEX_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                   : $urandom_range(0, live_taps - 1)),
                      rand_coef(), rand_coef());
        else if (pick < 93)
            send_plain(CMD_COMMIT);
        else
            send_plain(CMD_NONE);
    endtask

    // one register setting: a well-formed bank load and commit, then a random mix
    task automatic run_phase(logic [CFG_DATA_W-1:0] en_val, logic [CFG_DATA_W-1:0] taps_val,
                             int n_items);
        int unsigned live_taps;
        int unsigned n_load;
        int          sent;
        settle();
        cfg_write(CFG_TAP_COUNT, taps_val);
        cfg_write(CFG_FILTER_EN, en_val);
        n_settings++;
        live_taps = (taps_val == 0) ? 1 : ((taps_val > MAX_TAPS) ? MAX_TAPS : 32'(taps_val));
        n_load = $urandom_range(1, (live_taps < 12) ? live_taps : 12);
        for (int i = 0; i < n_load; i++)
            send_coef(TAP_INDEX_W'($urandom_range(0, live_taps - 1)), rand_coef(), rand_coef());
        send_plain(CMD_COMMIT);
        sent = n_load + 1;
        while (sent < n_items) begin
            random_request(live_taps);
            sent++;
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_FILTER_EN;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_NONE;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: pass-through with the filter off, short four-tap filter
        cfg_write(CFG_TAP_COUNT, 9'd4);
        cfg_write(CFG_FILTER_EN, 9'd0);
        n_settings++;
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample('0);
        send_plain(CMD_NONE);
        // bank loads and commit work while disabled
        send_coef(8'd0, COEF_MAX, COEF_MIN);
        send_coef(8'd1, COEF_MIN, COEF_MAX);
        send_coef(8'd255, 18'sd1, -18'sd1);
        send_sample('1);
        send_plain(CMD_COMMIT);

        settle();
        cfg_write(CFG_FILTER_EN, 9'd1);
        n_settings++;
        // full-scale samples against full-scale taps clip both ways
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample('0);
        send_sample(SAMPLE_BITS'(1));
        // staged only: the next sample must still use the old bank
        send_coef(8'd2, -18'sd1, 18'sd1);
        send_sample('1);
        send_plain(CMD_COMMIT);
        // line has wrapped past four entries by now
        send_sample(SAMPLE_BITS'(5));
        send_sample(SAMPLE_BITS'(-3));
        send_plain(CMD_NONE);

        for (int p = 0; p < N_PHASES; p++)
            run_phase(phase_en[p], phase_taps[p], RANDOM_ITEMS / N_PHASES);

        settle();
        $display("covered %0d samples, %0d coefficient writes, %0d commits, %0d unused requests",
                 n_samples, n_coefs, n_commits, n_unused);
        $display("over %0d register settings (%0d writes), %0d output pairs checked",
                 n_settings, n_cfg_writes, pairs_checked);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
sv/sfc_pkg.sv
sv/sfc_ram.sv
sv/sfc_mac.sv
sv/sfc_seq.sv
sv/stereo_fir_convolver_top.sv
verif/stereo_fir_convolver_checker.sv
verif/stereo_fir_convolver_top_tb.sv
